>>> rtl/idi_pkg.sv
package idi_pkg;

   localparam int MAX_NEIGHBORS_DEFAULT = 64;

   localparam int WEIGHT_WIDTH = 47;
   localparam int QUOT_WIDTH   = 31;

   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = WEIGHT_WIDTH'(65536);
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = {WEIGHT_WIDTH{1'b1}};
   localparam logic [63:0]             WSUM_MAX   = {1'b0, {63{1'b1}}};
   localparam logic [31:0]             ROUND_HALF = 32'h0000_8000;
   localparam logic [31:0]             INT32_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0]             INT32_MIN  = 32'h8000_0000;

   localparam logic [3:0]  POWER_RESET     = 4'd2;
   localparam logic [31:0] RADIUS_RESET    = 32'h0001_0000;
   localparam logic [31:0] THRESHOLD_RESET = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CSR_WEIGHT_POWER        = 2'd0,
      CSR_INVERSE_RADIUS      = 2'd1,
      CSR_EXACT_HIT_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_POW_LO,
      ST_POW_HI,
      ST_POW_RND,
      ST_TERM_LO,
      ST_TERM_HI,
      ST_TERM_SUM,
      ST_ACC,
      ST_END,
      ST_DIV_CHK,
      ST_DIV_WAIT
   } state_type;

   typedef struct packed {
      logic [31:0]        inv_distance;
      logic signed [31:0] neighbor_value;
      logic               last_neighbor;
   } req_type;

   typedef struct packed {
      logic signed [31:0] interpolated_value;
      logic               zero_weight_fault;
   } rsp_type;

   typedef struct packed {
      logic req_ready;
      logic mul_hi_sel;
      logic mul_term_sel;
      logic div_start;
   } ctl_type;

endpackage

>>> rtl/idi_mult.sv
module idi_mult
   import idi_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> rtl/idi_div.sv
module idi_div
   import idi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           num,
   input  logic [63:0]           den,
   output logic                  done,
   output logic [QUOT_WIDTH-1:0] quot
);

   localparam int CW = $clog2(QUOT_WIDTH + 1);

   logic                  busy_ff,  busy_in;
   logic                  done_ff,  done_in;
   logic [CW-1:0]         cnt_ff,   cnt_in;
   logic [63:0]           rem_ff,   rem_in;
   logic [63:0]           den_ff,   den_in;
   logic [QUOT_WIDTH-1:0] bits_ff,  bits_in;
   logic [QUOT_WIDTH-1:0] quot_ff,  quot_in;
   logic [63:0]           rem_sh;
   logic                  ge;

   // remainder stays below den < 2^63, so the shift cannot overflow
   assign rem_sh = {rem_ff[62:0], bits_ff[QUOT_WIDTH-1]};
   assign ge     = rem_sh >= den_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QUOT_WIDTH);
         rem_in  = {15'd0, num[63:15]};
         den_in  = den;
         bits_in = {num[14:0], 16'd0};
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sh - den_ff : rem_sh;
         quot_in = {quot_ff[QUOT_WIDTH-2:0], ge};
         bits_in = {bits_ff[QUOT_WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/inverse_distance_interpolator_core.sv
// A counted non-hit request adds term states between check and end, after a power loop
// of p = weight_power steps when a weight is formed; one shared 32x32 multiplier does the
// power and value products. End of run with a nonzero weight sum and no hit adds a range
// check, then the serial divider if the quotient is in range; a final request waits while
// a response is still held. Requests go one at a time; req_ready is high only when idle.
// Reset: synchronous, active high; clears sums, counters and output valid, loads defaults.
module inverse_distance_interpolator_core
   import idi_pkg::*;
#(
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

   state_type state_ff, state_in;
   ctl_type   ctl;

   logic [3:0]              power_ff,  power_in;
   logic [31:0]             radius_ff, radius_in;
   logic [31:0]             thresh_ff, thresh_in;

   logic [31:0]             inv_ff,    inv_in;
   logic signed [31:0]      val_ff,    val_in;
   logic                    last_ff,   last_in;
   logic [WEIGHT_WIDTH-1:0] w_ff,      w_in;
   logic [31:0]             d_ff,      d_in;
   logic [3:0]              pcnt_ff,   pcnt_in;
   logic [63:0]             plo_ff,    plo_in;
   logic [63:0]             term_ff,   term_in;
   logic signed [63:0]      wsum_ff,   wsum_in;
   logic [63:0]             wtsum_ff,  wtsum_in;
   logic                    hit_ff,    hit_in;
   logic [CNT_W-1:0]        cnt_ff,    cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff,  rsp_data_in;

   logic                    vneg;
   logic [31:0]             mv;
   logic [31:0]             mul_a, mul_b;
   logic [63:0]             mul_prod;
   logic [79:0]             full;
   logic [63:0]             shifted;
   logic signed [63:0]      st;
   logic signed [64:0]      sum65;
   logic [63:0]             wt_add;
   logic [63:0]             mn;
   logic                    ovf;
   logic                    skip;
   logic                    slot_free;
   logic                    res_wr;
   logic                    div_done;
   logic [QUOT_WIDTH-1:0]   div_quot;

   assign vneg      = val_ff[31];
   assign mv        = vneg ? 32'd0 - 32'(val_ff) : 32'(val_ff);
   assign skip      = hit_ff || (cnt_ff >= CNT_W'(MAX_NEIGHBORS));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign mn        = wsum_ff[63] ? 64'd0 - 64'(wsum_ff) : 64'(wsum_ff);
   assign ovf       = {15'd0, mn} >= {wtsum_ff, 15'd0};

   assign mul_a = ctl.mul_hi_sel ? 32'(w_ff[WEIGHT_WIDTH-1:32]) : w_ff[31:0];
   assign mul_b = ctl.mul_term_sel ? mv : d_ff;

   idi_mult u_mult (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   idi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.div_start),
      .num   (mn),
      .den   (wtsum_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (skip) begin
               state_in = ST_END;
            end else if (inv_ff > thresh_ff) begin
               state_in = ST_END;
            end else if (inv_ff < radius_ff || power_ff == 4'd0) begin
               state_in = ST_TERM_LO;
            end else begin
               state_in = ST_POW_LO;
            end
         end
         ST_POW_LO:   state_in = ST_POW_HI;
         ST_POW_HI:   state_in = ST_POW_RND;
         ST_POW_RND:  state_in = (pcnt_ff == 4'd1) ? ST_TERM_LO : ST_POW_LO;
         ST_TERM_LO:  state_in = ST_TERM_HI;
         ST_TERM_HI:  state_in = ST_TERM_SUM;
         ST_TERM_SUM: state_in = ST_ACC;
         ST_ACC:      state_in = ST_END;
         ST_END: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               state_in = (hit_ff || wtsum_ff == 64'd0) ? ST_IDLE : ST_DIV_CHK;
            end
         end
         ST_DIV_CHK:  state_in = ovf ? ST_IDLE : ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE:    ctl.req_ready    = 1'b1;
         ST_POW_HI:  ctl.mul_hi_sel   = 1'b1;
         ST_TERM_LO: ctl.mul_term_sel = 1'b1;
         ST_TERM_HI: begin
            ctl.mul_hi_sel   = 1'b1;
            ctl.mul_term_sel = 1'b1;
         end
         ST_DIV_CHK: ctl.div_start    = !ovf;
         default:    ctl = '0;
      endcase
   end

   assign res_wr = (state_ff == ST_END && last_ff && slot_free &&
                    (hit_ff || wtsum_ff == 64'd0)) ||
                   (state_ff == ST_DIV_CHK && ovf) ||
                   (state_ff == ST_DIV_WAIT && div_done);

   // datapath
   always_comb begin
      power_in     = power_ff;
      radius_in    = radius_ff;
      thresh_in    = thresh_ff;
      inv_in       = inv_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      w_in         = w_ff;
      d_in         = d_ff;
      pcnt_in      = pcnt_ff;
      plo_in       = plo_ff;
      term_in      = term_ff;
      wsum_in      = wsum_ff;
      wtsum_in     = wtsum_ff;
      hit_in       = hit_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      full         = (80'(mul_prod) << 32) + 80'(plo_ff);
      shifted      = '0;
      st           = vneg ? -$signed(term_ff) : $signed(term_ff);
      sum65        = {wsum_ff[63], wsum_ff} + {st[63], st};
      wt_add       = wtsum_ff + 64'(w_ff);

      if (csr_valid) begin
         case (csr_index)
            CSR_WEIGHT_POWER:        power_in  = csr_data[3:0];
            CSR_INVERSE_RADIUS:      radius_in = csr_data;
            CSR_EXACT_HIT_THRESHOLD: thresh_in = csr_data;
            default:                 power_in  = power_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               inv_in  = req_data.inv_distance;
               val_in  = req_data.neighbor_value;
               last_in = req_data.last_neighbor;
            end
         end
         ST_CHECK: begin
            if (!skip) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (inv_ff > thresh_ff) begin
                  hit_in  = 1'b1;
                  wsum_in = 64'(val_ff);
               end else if (inv_ff < radius_ff) begin
                  w_in = '0;
               end else begin
                  w_in    = WEIGHT_ONE;
                  d_in    = inv_ff - radius_ff;
                  pcnt_in = power_ff;
               end
            end
         end
         ST_POW_HI, ST_TERM_HI: plo_in = mul_prod;
         ST_POW_RND: begin
            shifted = 64'((full + 80'(ROUND_HALF)) >> 16);
            w_in    = (shifted > 64'(WEIGHT_MAX)) ? WEIGHT_MAX : shifted[WEIGHT_WIDTH-1:0];
            pcnt_in = pcnt_ff - 4'd1;
         end
         ST_TERM_SUM: term_in = full[79:16];
         ST_ACC: begin
            if (sum65[64] != sum65[63]) begin
               wsum_in = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
               wsum_in = sum65[63:0];
            end
            wtsum_in = (wt_add > WSUM_MAX) ? WSUM_MAX : wt_add;
         end
         ST_END: begin
            if (res_wr) begin
               if (hit_ff) begin
                  rsp_data_in.interpolated_value = wsum_ff[31:0];
                  rsp_data_in.zero_weight_fault  = 1'b0;
               end else begin
                  rsp_data_in.interpolated_value = '0;
                  rsp_data_in.zero_weight_fault  = 1'b1;
               end
            end
         end
         ST_DIV_CHK: begin
            rsp_data_in.interpolated_value = wsum_ff[63] ? INT32_MIN : INT32_MAX;
            rsp_data_in.zero_weight_fault  = 1'b0;
         end
         ST_DIV_WAIT: begin
            rsp_data_in.interpolated_value = wsum_ff[63] ? 32'd0 - {1'b0, div_quot}
                                                         : {1'b0, div_quot};
            rsp_data_in.zero_weight_fault  = 1'b0;
         end
         default: cnt_in = cnt_ff;
      endcase

      if (res_wr) begin
         wsum_in  = '0;
         wtsum_in = '0;
         hit_in   = 1'b0;
         cnt_in   = '0;
      end

      rsp_valid_in = res_wr ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         power_ff     <= POWER_RESET;
         radius_ff    <= RADIUS_RESET;
         thresh_ff    <= THRESHOLD_RESET;
         wsum_ff      <= '0;
         wtsum_ff     <= '0;
         hit_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         power_ff     <= power_in;
         radius_ff    <= radius_in;
         thresh_ff    <= thresh_in;
         wsum_ff      <= wsum_in;
         wtsum_ff     <= wtsum_in;
         hit_ff       <= hit_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      inv_ff      <= inv_in;
      val_ff      <= val_in;
      last_ff     <= last_in;
      w_ff        <= w_in;
      d_ff        <= d_in;
      pcnt_ff     <= pcnt_in;
      plo_ff      <= plo_in;
      term_ff     <= term_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = ctl.req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_slot_free_on_write: assert property (@(posedge clock) disable iff (reset)
      res_wr |-> slot_free)
      else $error("result written over a pending response");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_NEIGHBORS))
      else $error("neighbour count beyond cap");

   a_power_loop_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POW_LO) |-> (pcnt_ff != 4'd0))
      else $error("power step with zero count");

   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside wait state");

endmodule
